/* src/mnplt_pkg.sv */
// ----------------------------------------------------------------------------
// mnplt_pkg
// Shared constants and types for the MIDI note parser with link timeout.
// ----------------------------------------------------------------------------
package mnplt_pkg;

    localparam int TIMER_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = TIMER_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CC_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIMEOUT = 2'd2;

    // reset values of the timeout registers, in ticks
    localparam logic [TIMER_W-1:0] LONG_TIMEOUT_RST  = 17'd90000;
    localparam logic [TIMER_W-1:0] SHORT_TIMEOUT_RST = 17'd1000;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // status byte codes (upper nibble for channel messages)
    localparam logic [3:0] KIND_NOTE_ON      = 4'h9;
    localparam logic [3:0] KIND_CTRL_CHANGE  = 4'hB;
    localparam logic [7:0] STATUS_ACT_SENSE  = 8'hFE;

    // bytes collected of the current message
    typedef enum logic [1:0] {
        CNT_NONE   = 2'd0,
        CNT_STATUS = 2'd1,
        CNT_DATA1  = 2'd2
    } byte_cnt_t;

endpackage

/* src/midi_note_parser_with_link_timeout.sv */
// ----------------------------------------------------------------------------
// midi_note_parser_with_link_timeout
// MIDI Note On / Control Change parser with running status and link timeout.
// ----------------------------------------------------------------------------
// Accepts one item (a received MIDI byte or a one-millisecond tick) in every
// clock cycle with in_stall low and gives exactly one result per item, in the
// cycle after it is accepted. The parser state and the timeout counter are
// updated in the same cycle as the item is accepted, and the result is held in
// a single output register; in_stall is raised only while that register holds
// a result that the downstream side is stalling, so the sustained rate is one
// item per cycle while out_stall is low. A result carries a completed
// three-byte message (fields are zero when msg_valid is low) and the connect
// and disconnect events of the link. Configuration registers are written
// through cfg_we / cfg_index / cfg_data and take effect on the next item.
module midi_note_parser_with_link_timeout
    import mnplt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  logic [7:0]           rx_byte,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 msg_valid,
    output logic [7:0]           msg_status,
    output logic [6:0]           msg_data1,
    output logic [6:0]           msg_data2,
    output logic                 connect_event,
    output logic                 disconnect_event
);

    // configuration
    logic               cc_enable_reg;
    logic [TIMER_W-1:0] long_timeout_reg;
    logic [TIMER_W-1:0] short_timeout_reg;

    // parser and link state
    logic [7:0]         held_status_reg, held_status_next;
    logic [6:0]         held_data1_reg, held_data1_next;
    byte_cnt_t          byte_count_reg, byte_count_next;
    logic               sense_seen_reg, sense_seen_next;
    logic               link_up_reg, link_up_next;
    logic               timer_armed_reg, timer_armed_next;
    logic [TIMER_W-1:0] timer_left_reg, timer_left_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               msg_valid_reg, msg_valid_next;
    logic [7:0]         msg_status_reg, msg_status_next;
    logic [6:0]         msg_data1_reg, msg_data1_next;
    logic [6:0]         msg_data2_reg, msg_data2_next;
    logic               connect_reg, connect_next;
    logic               disconnect_reg, disconnect_next;

    logic               in_accept;
    logic               capture;
    logic [TIMER_W-1:0] period;
    logic [TIMER_W-1:0] left_dec;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_enable_reg     <= 1'b0;
            long_timeout_reg  <= LONG_TIMEOUT_RST;
            short_timeout_reg <= SHORT_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CC_ENABLE:     cc_enable_reg     <= cfg_data[0];
                REG_LONG_TIMEOUT:  long_timeout_reg  <= cfg_data;
                REG_SHORT_TIMEOUT: short_timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        capture = (rx_byte[7:4] == KIND_NOTE_ON)
               || (cc_enable_reg && (rx_byte[7:4] == KIND_CTRL_CHANGE));

        // active sensing counts already for the restart it causes
        sense_seen_next = sense_seen_reg;
        if (!op && (rx_byte == STATUS_ACT_SENSE))
            sense_seen_next = 1'b1;

        period = sense_seen_next ? short_timeout_reg : long_timeout_reg;
        if (period == '0)
            period = TIMER_W'(1);

        left_dec = (timer_left_reg != '0) ? timer_left_reg - TIMER_W'(1) : '0;

        held_status_next = held_status_reg;
        held_data1_next  = held_data1_reg;
        byte_count_next  = byte_count_reg;
        link_up_next     = link_up_reg;
        timer_armed_next = timer_armed_reg;
        timer_left_next  = timer_left_reg;

        msg_valid_next   = 1'b0;
        msg_status_next  = '0;
        msg_data1_next   = '0;
        msg_data2_next   = '0;
        connect_next     = 1'b0;
        disconnect_next  = 1'b0;

        if (op == OP_TICK)
        begin
            if (timer_armed_reg)
            begin
                timer_left_next = left_dec;
                if (left_dec == '0)
                begin
                    timer_armed_next = 1'b0;
                    if (link_up_reg)
                    begin
                        disconnect_next = 1'b1;
                        link_up_next    = 1'b0;
                    end
                end
            end
        end
        else if (!rx_byte[7])
        begin
            // data byte, ignored without a held status
            unique case (byte_count_reg)
                CNT_STATUS:
                begin
                    held_data1_next = rx_byte[6:0];
                    byte_count_next = CNT_DATA1;
                end
                CNT_DATA1:
                begin
                    msg_valid_next  = 1'b1;
                    msg_status_next = held_status_reg;
                    msg_data1_next  = held_data1_reg;
                    msg_data2_next  = rx_byte[6:0];
                    byte_count_next = CNT_STATUS;   // running status
                end
                default: ;
            endcase
        end
        else
        begin
            if (capture)
            begin
                held_status_next = rx_byte;
                byte_count_next  = CNT_STATUS;
            end
            else
            begin
                byte_count_next  = CNT_NONE;
            end
            if (!link_up_reg)
            begin
                connect_next = 1'b1;
                link_up_next = 1'b1;
            end
            timer_left_next  = period;
            timer_armed_next = 1'b1;
        end

        if (in_accept)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= CNT_NONE;
            sense_seen_reg  <= 1'b0;
            link_up_reg     <= 1'b0;
            timer_armed_reg <= 1'b0;
            timer_left_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                byte_count_reg  <= byte_count_next;
                sense_seen_reg  <= sense_seen_next;
                link_up_reg     <= link_up_next;
                timer_armed_reg <= timer_armed_next;
                timer_left_reg  <= timer_left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            held_status_reg <= held_status_next;
            held_data1_reg  <= held_data1_next;
            msg_valid_reg   <= msg_valid_next;
            msg_status_reg  <= msg_status_next;
            msg_data1_reg   <= msg_data1_next;
            msg_data2_reg   <= msg_data2_next;
            connect_reg     <= connect_next;
            disconnect_reg  <= disconnect_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign msg_valid        = msg_valid_reg;
    assign msg_status       = msg_status_reg;
    assign msg_data1        = msg_data1_reg;
    assign msg_data2        = msg_data2_reg;
    assign connect_event    = connect_reg;
    assign disconnect_event = disconnect_reg;

    // the counter runs exactly while armed
    a_timer_armed: assert property (@(posedge clk) disable iff (!rst_n)
        timer_armed_reg == (timer_left_reg != '0))
        else $error("timer armed flag and count disagree");

    // a link cannot go up and down on the same item
    a_event_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(connect_event && disconnect_event))
        else $error("connect and disconnect in one result");

    // a tick never completes a message or connects the link
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (op == OP_TICK)) |=> (!msg_valid && !connect_event))
        else $error("tick produced a message or connect event");

    // a disconnect leaves the link down and the timer idle
    a_disc_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && disconnect_next) |=> (!link_up_reg && !timer_armed_reg))
        else $error("link state wrong after disconnect");

endmodule
